/* hw/rtl/edsv_pkg.sv */
// Shared constants, types and helper function for the EDID stream validator.
package edsv_pkg;

    localparam int MAX_BLOCKS = 2;
    localparam int BLK        = 128;
    localparam int OFF_W      = $clog2(BLK);
    localparam int WINDOW     = MAX_BLOCKS * BLK;
    localparam int POS_W      = $clog2(WINDOW + 1);
    localparam int BLK_W      = POS_W - OFF_W;
    localparam int CMP_W      = (BLK_W > 8) ? BLK_W : 8;
    localparam int FB_W       = 2;

    localparam logic [OFF_W-1:0] OFF_HDR_END  = OFF_W'(8);
    localparam logic [OFF_W-1:0] OFF_VERSION  = OFF_W'(18);
    localparam logic [OFF_W-1:0] OFF_REVISION = OFF_W'(19);
    localparam logic [OFF_W-1:0] OFF_EXT_CNT  = OFF_W'(126);
    localparam logic [OFF_W-1:0] OFF_CHKSUM   = OFF_W'(127);

    localparam logic [7:0] VERSION_ONE  = 8'd1;
    localparam logic [7:0] REVISION_MAX = 8'd4;
    localparam logic [7:0] DAMAGED_SUM  = 8'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic hdr;
        logic zero;
        logic ones;
    } block_flags_t;

    typedef struct packed {
        logic base;
        logic ext;
        logic sums;
    } verdict_flags_t;

    typedef struct packed {
        logic            is_edid;
        logic            header_exact;
        logic            header_damaged_pattern;
        logic            extensions_valid;
        logic            checksums_valid;
        logic [FB_W-1:0] full_blocks;
    } result_t;

    function automatic logic [7:0] header_byte(input logic [2:0] off);
        begin
            header_byte = (off == 3'd0 || off == 3'd7) ? 8'h00 : 8'hFF;
        end
    endfunction

endpackage

/* hw/rtl/edid_stream_validator.sv */
// Top level of the EDID stream validator.
//
// Usage:
//   Bytes of one EDID data set enter on the byte channel (byte_valid,
//   byte_ready, data_byte, last_byte), one byte per transfer, with last_byte
//   high on the final byte. Exactly one verdict leaves on the verdict channel
//   (verdict_valid, verdict_ready and the six result fields) per data set.
//   Bytes beyond the examined window are accepted and ignored.
// Throughput and pipeline:
//   One byte per cycle, except while a last byte waits for the pending verdict.
//   After the last byte transfers, it sits in the input register, then the
//   verdict goes to the result register. The per-byte work is an 8-bit
//   running sum plus a few flag updates.
// Reset:
//   rst_n clears both pipeline registers and returns the running state to
//   the start of a data set; no clearing pass is needed.
// Stall:
//   While a verdict waits for verdict_ready, bytes of the next data set keep
//   flowing; only the next last byte holds in the input register, and
//   byte_ready drops, until the waiting verdict is taken.
module edid_stream_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       verdict_valid,
    input  logic       verdict_ready,
    output logic       is_edid,
    output logic       header_exact,
    output logic       header_damaged_pattern,
    output logic       extensions_valid,
    output logic       checksums_valid,
    output logic [1:0] full_blocks
);
    import edsv_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    fire;
    logic    out_busy;
    logic    res_valid;
    result_t res;
    result_t verdict;

    edsv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    edsv_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_busy   (out_busy),
        .fire       (fire),
        .res_valid  (res_valid),
        .res        (res)
    );

    edsv_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .out_busy      (out_busy),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict       (verdict)
    );

    assign is_edid                = verdict.is_edid;
    assign header_exact           = verdict.header_exact;
    assign header_damaged_pattern = verdict.header_damaged_pattern;
    assign extensions_valid       = verdict.extensions_valid;
    assign checksums_valid        = verdict.checksums_valid;
    assign full_blocks            = verdict.full_blocks;

endmodule

/* hw/rtl/edsv_in_stage.sv */
// Input register: holds one accepted byte until the core consumes it.
module edsv_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_ready,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    input  logic          fire,
    output logic          item_valid,
    output edsv_pkg::item_t item
);
    import edsv_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign byte_ready = !valid_reg || fire;
    assign valid_next = (byte_valid && byte_ready) ? 1'b1 : (fire ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            item_reg <= '{data_byte: data_byte, last_byte: last_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/edsv_core.sv */
// Running block state and end-of-set verdict logic.
module edsv_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  edsv_pkg::item_t   item,
    input  logic              out_busy,
    output logic              fire,
    output logic              res_valid,
    output edsv_pkg::result_t res
);
    import edsv_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       block_sum_reg, block_sum_next;
    logic [7:0]       tail_sum_reg, tail_sum_next;
    logic             header_match_reg, header_match_next;
    logic             version_ok_reg, version_ok_next;
    logic [7:0]       ext_count_reg, ext_count_next;
    block_flags_t     block_flags_reg, block_flags_next;
    verdict_flags_t   verdict_flags_reg, verdict_flags_next;

    logic [OFF_W-1:0] off, end_off;
    logic [BLK_W-1:0] blk, end_blk;
    logic [7:0]       d;
    logic             hdr_miss;
    logic             ext_ok;
    logic             exact, damaged;

    assign fire      = item_valid && !(item.last_byte && out_busy);
    assign res_valid = fire && item.last_byte;
    assign d         = item.data_byte;
    assign off       = pos_reg[OFF_W-1:0];
    assign blk       = pos_reg[POS_W-1:OFF_W];
    assign hdr_miss  = (off < OFF_HDR_END) && (d != header_byte(off[2:0]));

    always_comb
    begin
        pos_next           = pos_reg;
        block_sum_next     = block_sum_reg;
        tail_sum_next      = tail_sum_reg;
        header_match_next  = header_match_reg;
        version_ok_next    = version_ok_reg;
        ext_count_next     = ext_count_reg;
        block_flags_next   = block_flags_reg;
        verdict_flags_next = verdict_flags_reg;

        if (pos_reg < POS_W'(WINDOW))
        begin
            if (off == '0)
            begin
                block_sum_next   = 8'h00;
                block_flags_next = '{hdr: 1'b1, zero: 1'b1, ones: 1'b1};
            end
            block_sum_next = block_sum_next + d;
            if (hdr_miss)
            begin
                block_flags_next.hdr = 1'b0;
            end
            if (off != OFF_CHKSUM)
            begin
                if (d != 8'h00)
                begin
                    block_flags_next.zero = 1'b0;
                end
                if (d != 8'hFF)
                begin
                    block_flags_next.ones = 1'b0;
                end
            end

            if (blk == '0)
            begin
                if (hdr_miss)
                begin
                    header_match_next = 1'b0;
                end
                if (off >= OFF_HDR_END)
                begin
                    tail_sum_next = tail_sum_reg + d;
                end
                if (off == OFF_VERSION)
                begin
                    version_ok_next = (d == VERSION_ONE);
                end
                if (off == OFF_REVISION && d > REVISION_MAX)
                begin
                    version_ok_next = 1'b0;
                end
                if (off == OFF_EXT_CNT)
                begin
                    ext_count_next = d;
                end
                if (off == OFF_CHKSUM)
                begin
                    verdict_flags_next.base = 1'b1;
                    if (block_sum_next != 8'h00)
                    begin
                        verdict_flags_next.sums = 1'b0;
                    end
                end
            end
            else if (off == OFF_CHKSUM && CMP_W'(blk) <= CMP_W'(ext_count_reg))
            begin
                if (block_flags_next.hdr || block_flags_next.zero || block_flags_next.ones)
                begin
                    verdict_flags_next.ext = 1'b0;
                end
                else if (block_sum_next != 8'h00)
                begin
                    verdict_flags_next.sums = 1'b0;
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    assign end_off = pos_next[OFF_W-1:0];
    assign end_blk = pos_next[POS_W-1:OFF_W];

    always_comb
    begin
        ext_ok = verdict_flags_next.ext;
        if (verdict_flags_next.base && end_off != '0 && end_blk != '0
            && CMP_W'(end_blk) <= CMP_W'(ext_count_next))
        begin
            ext_ok = 1'b0;
        end
        exact   = verdict_flags_next.base && header_match_next;
        damaged = verdict_flags_next.base && version_ok_next
                  && (tail_sum_next == DAMAGED_SUM);
        res.is_edid                = exact || damaged;
        res.header_exact           = exact;
        res.header_damaged_pattern = damaged;
        res.extensions_valid       = verdict_flags_next.base && ext_ok;
        res.checksums_valid        = verdict_flags_next.base && verdict_flags_next.sums;
        res.full_blocks            = FB_W'(end_blk);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            block_sum_reg     <= 8'h00;
            tail_sum_reg      <= 8'h00;
            header_match_reg  <= 1'b1;
            version_ok_reg    <= 1'b0;
            ext_count_reg     <= 8'h00;
            block_flags_reg   <= '{hdr: 1'b1, zero: 1'b1, ones: 1'b1};
            verdict_flags_reg <= '{base: 1'b0, ext: 1'b1, sums: 1'b1};
        end
        else if (fire)
        begin
            if (item.last_byte)
            begin
                pos_reg           <= '0;
                block_sum_reg     <= 8'h00;
                tail_sum_reg      <= 8'h00;
                header_match_reg  <= 1'b1;
                version_ok_reg    <= 1'b0;
                ext_count_reg     <= 8'h00;
                block_flags_reg   <= '{hdr: 1'b1, zero: 1'b1, ones: 1'b1};
                verdict_flags_reg <= '{base: 1'b0, ext: 1'b1, sums: 1'b1};
            end
            else
            begin
                pos_reg           <= pos_next;
                block_sum_reg     <= block_sum_next;
                tail_sum_reg      <= tail_sum_next;
                header_match_reg  <= header_match_next;
                version_ok_reg    <= version_ok_next;
                ext_count_reg     <= ext_count_next;
                block_flags_reg   <= block_flags_next;
                verdict_flags_reg <= verdict_flags_next;
            end
        end
    end

endmodule

/* hw/rtl/edsv_out_stage.sv */
// Result register: holds one verdict until the receiver takes the transfer.
module edsv_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  edsv_pkg::result_t res,
    output logic              out_busy,
    output logic              verdict_valid,
    input  logic              verdict_ready,
    output edsv_pkg::result_t verdict
);
    import edsv_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_busy   = valid_reg && !verdict_ready;
    assign valid_next = res_valid ? 1'b1 : (verdict_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign verdict_valid = valid_reg;
    assign verdict       = res_reg;

endmodule

/* hw/rtl/edsv_checker.sv */
// Port-level checker for the EDID stream validator, bound to the top level.
module edsv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       byte_valid,
    input logic       byte_ready,
    input logic       last_byte,
    input logic       verdict_valid,
    input logic       verdict_ready,
    input logic       is_edid,
    input logic       header_exact,
    input logic       header_damaged_pattern,
    input logic       extensions_valid,
    input logic       checksums_valid,
    input logic [1:0] full_blocks
);

    a_verdict_holds: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && !verdict_ready |=> verdict_valid)
        else $error("verdict dropped before transfer");

    a_is_edid_or: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (is_edid == (header_exact || header_damaged_pattern)))
        else $error("is_edid disagrees with header results");

    a_short_set: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && full_blocks == 2'd0 |->
            !is_edid && !extensions_valid && !checksums_valid)
        else $error("short data set reported as valid");

    a_verdict_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(verdict_valid) |-> $past(byte_valid && byte_ready && last_byte, 2))
        else $error("verdict without a last byte two cycles earlier");

endmodule

bind edid_stream_validator edsv_checker u_edsv_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .byte_valid             (byte_valid),
    .byte_ready             (byte_ready),
    .last_byte              (last_byte),
    .verdict_valid          (verdict_valid),
    .verdict_ready          (verdict_ready),
    .is_edid                (is_edid),
    .header_exact           (header_exact),
    .header_damaged_pattern (header_damaged_pattern),
    .extensions_valid       (extensions_valid),
    .checksums_valid        (checksums_valid),
    .full_blocks            (full_blocks)
);
